/* rtl/ax25_pkg.sv */
package ax25_pkg;

   localparam int STUFF_RUN_DEFAULT = 5;

   localparam int BYTE_BITS = 8;
   localparam int FCS_BITS  = 16;
   localparam int CRC_W     = 16;
   localparam int RUN_W     = 8;
   // bit counter holds 0..FCS_BITS
   localparam int LEFT_W    = $clog2(FCS_BITS + 1);

   localparam logic [CRC_W-1:0] CRC_POLY   = 16'h8408;
   localparam logic [CRC_W-1:0] CRC_PRESET = 16'hFFFF;

   localparam logic [1:0] ACT_SEND   = 2'd0;
   localparam logic [1:0] ACT_FCS    = 2'd1;
   localparam logic [1:0] ACT_PRESET = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       stuff_enable;
   } req_type;

   typedef struct packed {
      logic tone_mark;
      logic is_stuffed;
      logic last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_FCS,
      OP_PRESET
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       stuff_enable;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_STUFF
   } state_type;

endpackage

/* rtl/ax25_front.sv */
module ax25_front (
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ax25_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              q_push,
   output ax25_pkg::cmd_type q_cmd
);

   logic known;

   always_comb begin
      known             = 1'b1;
      q_cmd.op          = ax25_pkg::OP_SEND;
      q_cmd.data_byte   = req_payload.data_byte;
      q_cmd.stuff_enable = req_payload.stuff_enable;
      unique case (req_payload.action)
         ax25_pkg::ACT_SEND:   q_cmd.op = ax25_pkg::OP_SEND;
         ax25_pkg::ACT_FCS:    q_cmd.op = ax25_pkg::OP_FCS;
         ax25_pkg::ACT_PRESET: q_cmd.op = ax25_pkg::OP_PRESET;
         default:              known = 1'b0; // unused code is dropped here
      endcase
   end

   assign req_ready = !q_full && !reset;
   assign q_push    = req_valid && req_ready && known;

endmodule

/* rtl/ax25_queue.sv */
module ax25_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ax25_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ax25_pkg::cmd_type head_cmd
);

   ax25_pkg::cmd_type                  entries_ff [ax25_pkg::QUEUE_DEPTH];
   logic [ax25_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ax25_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ax25_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push, do_pop;

   assign full      = count_ff == ax25_pkg::QCNT_W'(ax25_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_cmd  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/ax25_back.sv */
module ax25_back #(
   parameter int StuffRun = ax25_pkg::STUFF_RUN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ax25_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ax25_pkg::rsp_type rsp_payload
);

   ax25_pkg::state_type                state_ff, state_in;
   logic [ax25_pkg::CRC_W-1:0]         crc_ff, crc_in;
   logic [ax25_pkg::FCS_BITS-1:0]      shift_ff, shift_in;
   logic [ax25_pkg::LEFT_W-1:0]        left_ff, left_in;
   logic [ax25_pkg::RUN_W-1:0]         run_ff, run_in;
   logic                               level_ff, level_in;
   logic                               stuff_ff, stuff_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ax25_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               can_emit;
   logic                               bit_val;
   logic                               stuff_hit;
   logic [ax25_pkg::RUN_W-1:0]         run_next;
   logic [ax25_pkg::CRC_W-1:0]         crc_shr;

   assign can_emit    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      run_in       = run_ff;
      level_in     = level_ff;
      stuff_in     = stuff_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      bit_val      = shift_ff[0];
      stuff_hit    = 1'b0;
      run_next     = run_ff + 1'b1;
      crc_shr      = crc_ff >> 1;

      unique case (state_ff)
         ax25_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  ax25_pkg::OP_SEND: begin
                     shift_in = ax25_pkg::FCS_BITS'(q_cmd.data_byte);
                     left_in  = ax25_pkg::LEFT_W'(ax25_pkg::BYTE_BITS);
                     stuff_in = q_cmd.stuff_enable;
                     state_in = ax25_pkg::ST_BIT;
                  end
                  ax25_pkg::OP_FCS: begin
                     // FCS goes out low byte first, so the inverted CRC shifts LSB first
                     shift_in = ~crc_ff;
                     left_in  = ax25_pkg::LEFT_W'(ax25_pkg::FCS_BITS);
                     stuff_in = 1'b1;
                     state_in = ax25_pkg::ST_BIT;
                  end
                  ax25_pkg::OP_PRESET: begin
                     crc_in = ax25_pkg::CRC_PRESET;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ax25_pkg::ST_BIT: begin
            if (can_emit) begin
               crc_in   = (crc_ff[0] ^ bit_val) ? (crc_shr ^ ax25_pkg::CRC_POLY) : crc_shr;
               shift_in = shift_ff >> 1;
               left_in  = left_ff - 1'b1;
               if (bit_val) begin
                  if (stuff_ff && run_next == ax25_pkg::RUN_W'(StuffRun)) begin
                     stuff_hit = 1'b1;
                     run_in    = '0;
                  end else begin
                     run_in = run_next;
                  end
               end else begin
                  level_in = !level_ff;
                  run_in   = '0;
               end
               rsp_valid_in      = 1'b1;
               rsp_in.tone_mark  = level_in;
               rsp_in.is_stuffed = 1'b0;
               rsp_in.last       = (left_ff == ax25_pkg::LEFT_W'(1)) && !stuff_hit;
               if (stuff_hit) begin
                  state_in = ax25_pkg::ST_STUFF;
               end else if (left_ff == ax25_pkg::LEFT_W'(1)) begin
                  state_in = ax25_pkg::ST_IDLE;
               end
            end
         end
         ax25_pkg::ST_STUFF: begin
            if (can_emit) begin
               level_in          = !level_ff;
               run_in            = '0;
               rsp_valid_in      = 1'b1;
               rsp_in.tone_mark  = !level_ff;
               rsp_in.is_stuffed = 1'b1;
               rsp_in.last       = left_ff == '0;
               state_in          = (left_ff == '0) ? ax25_pkg::ST_IDLE : ax25_pkg::ST_BIT;
            end
         end
         default: begin
            state_in = ax25_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ax25_pkg::ST_IDLE;
         crc_ff       <= ax25_pkg::CRC_PRESET;
         run_ff       <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         run_ff       <= run_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      left_ff  <= left_in;
      stuff_ff <= stuff_in;
      rsp_ff   <= rsp_in;
   end

endmodule

/* rtl/ax25_nrzi_bit_stuffer_fcs_unit.sv */
// channel  | valid     | ready     | payload
// request  | req_valid | req_ready | req_payload (action, data_byte, stuff_enable)
// response | rsp_valid | rsp_ready | rsp_payload (tone_mark, is_stuffed, last)
//
// The symbol engine, while sending and not stalled, emits one NRZI symbol per cycle; a loaded
// byte yields 8 data symbols plus stuffing, an FCS 16 plus stuffing, a preset none.
// A two-entry request queue sits between decode and the symbol engine.
// Synchronous active-high reset: CRC preset to 0xFFFF, line level low, run count 0.
// A stalled response holds the engine; requests keep queuing until the queue fills.
module ax25_nrzi_bit_stuffer_fcs_unit #(
   parameter int StuffRun = ax25_pkg::STUFF_RUN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ax25_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ax25_pkg::rsp_type rsp_payload
);

   logic              q_push, q_full, q_pop, q_not_empty;
   ax25_pkg::cmd_type push_cmd, head_cmd;

   ax25_front u_front (
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   ax25_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   ax25_back #(
      .StuffRun (StuffRun)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
